>>> rtl/core/arbe_pkg.sv
// Shared types and constants for the adaptive Rice bit encoder.
// Holds operation codes, FSM state type and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package arbe_pkg;

    localparam int MAX_UNARY     = 32;
    localparam int VALUE_BITS    = 16;
    localparam int CODE_CAP_BITS = 48;
    localparam int K_LIMIT       = 15;
    localparam int MAX_RESULTS   = 6;

    localparam logic [16:0] VALUE_MASK =
        (VALUE_BITS >= 17) ? 17'h1FFFF : 17'((18'd1 << VALUE_BITS) - 18'd1);

    localparam logic [2:0] FUNC_RAW      = 3'd0;
    localparam logic [2:0] FUNC_RICE     = 3'd1;
    localparam logic [2:0] FUNC_SRICE    = 3'd2;
    localparam logic [2:0] FUNC_RICE_DC  = 3'd3;
    localparam logic [2:0] FUNC_SRICE_DC = 3'd4;
    localparam logic [2:0] FUNC_FLUSH    = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic calc;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic last_byte;
    } t_status;

endpackage

>>> rtl/core/arbe_ctrl.sv
// Controller FSM of the adaptive Rice bit encoder: accept, code setup, byte emission.
// Depends on arbe_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps

module arbe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  arbe_pkg::t_status i_status,
    output arbe_pkg::t_cmd    o_cmd
);

    arbe_pkg::t_state r_state;
    arbe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arbe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_stall    = 1'b1;
        case (r_state)
            arbe_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = arbe_pkg::ST_CALC;
                end
            end
            arbe_pkg::ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = arbe_pkg::ST_EMIT;
            end
            arbe_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_byte) begin
                        n_state = arbe_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = arbe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/arbe_dp.sv
// Datapath of the adaptive Rice bit encoder: value mapping, code layout, byte generation,
// pending-bit state and the output register. Depends on arbe_pkg.
`timescale 1ns / 1ps

module arbe_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  arbe_pkg::t_cmd    i_cmd,
    output arbe_pkg::t_status o_status,
    input  logic [2:0]        i_func,
    input  logic signed [16:0] i_value,
    input  logic [4:0]        i_nbits,
    input  logic [3:0]        i_k_in,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_byte_valid,
    output logic [7:0]        o_out_byte,
    output logic [3:0]        o_k_out,
    output logic              o_overflow_error,
    output logic              o_last
);

    // stream bit at position p: old pending bits, ones, separator zero, data, then zeros
    function automatic logic gen_bit(input logic [6:0] p, input logic [6:0] pc,
                                     input logic [6:0] a, input logic [6:0] e,
                                     input logic [6:0] t, input logic [7:0] pb,
                                     input logic [16:0] dv);
        logic [6:0] j;
        logic       b;
        j = t - 7'd1 - p;
        if (p < pc) begin
            b = pb[3'd7 - p[2:0]];
        end else if (p < a) begin
            b = 1'b1;
        end else if (p < e) begin
            b = 1'b0;
        end else if (p < t) begin
            b = (j < 7'd17) ? dv[j[4:0]] : 1'b0;
        end else begin
            b = 1'b0;
        end
        return b;
    endfunction

    // stage 1
    logic [2:0]  r_func;
    logic [16:0] r_v;
    logic [16:0] r_q;
    logic [4:0]  r_vlen;
    logic [3:0]  r_k;
    logic [4:0]  r_nb;
    logic [16:0] n_v;
    logic [4:0]  n_vlen;
    logic [16:0] w_raw;

    // stage 2
    logic [6:0]  r_a;
    logic [6:0]  r_e;
    logic [6:0]  r_t;
    logic [2:0]  r_nres;
    logic [3:0]  r_kn;
    logic        r_err;
    logic [2:0]  r_bidx;

    logic [6:0]  w_u;
    logic        w_z;
    logic [6:0]  w_l;
    logic [3:0]  w_kn;
    logic        w_err;
    logic [6:0]  w_a;
    logic [6:0]  w_e;
    logic [6:0]  w_t;
    logic [4:0]  w_grp;
    logic [2:0]  w_cnt;
    logic [6:0]  w_esc_l;
    logic [3:0]  w_rice_k;
    logic [3:0]  w_esc_k;
    logic [4:0]  w_esc_sum;
    logic        w_dc_esc;
    logic        w_rice_err;

    // pending state and output register
    logic [2:0]  r_pc;
    logic [7:0]  r_pb;
    logic        r_out_valid;
    logic        r_byte_valid;
    logic [7:0]  r_out_byte;
    logic [3:0]  r_k_out;
    logic        r_err_out;
    logic        r_last;

    logic [6:0]  w_base;
    logic [6:0]  w_pbase;
    logic [7:0]  w_byte;
    logic [7:0]  w_pend;
    logic        w_last;

    assign w_raw = $unsigned(i_value);

    always_comb begin
        case (i_func)
            arbe_pkg::FUNC_RAW: begin
                n_v = w_raw;
            end
            arbe_pkg::FUNC_RICE, arbe_pkg::FUNC_RICE_DC: begin
                n_v = w_raw & arbe_pkg::VALUE_MASK;
            end
            arbe_pkg::FUNC_SRICE, arbe_pkg::FUNC_SRICE_DC: begin
                n_v = w_raw[16] ? {~w_raw[15:0], 1'b1} : {w_raw[15:0], 1'b0};
            end
            default: begin
                n_v = '0;
            end
        endcase
        n_vlen = '0;
        for (int b = 0; b < 17; b++) begin
            if (n_v[b]) begin
                n_vlen = 5'(b + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_v    <= n_v;
            r_q    <= n_v >> i_k_in;
            r_vlen <= n_vlen;
            r_k    <= i_k_in;
            r_nb   <= (i_nbits > 5'd16) ? 5'd16 : i_nbits;
        end
    end

    always_comb begin
        w_grp = 5'd5 + {1'b0, r_k};
        if (r_vlen <= w_grp) begin
            w_cnt = 3'd1;
        end else if ({1'b0, r_vlen} <= {w_grp, 1'b0}) begin
            w_cnt = 3'd2;
        end else if ({2'b0, r_vlen} <= ({2'b0, w_grp} + {1'b0, w_grp, 1'b0})) begin
            w_cnt = 3'd3;
        end else begin
            w_cnt = 3'd4;
        end
        case (w_cnt)
            3'd1:    w_esc_l = {2'b0, w_grp};
            3'd2:    w_esc_l = {1'b0, w_grp, 1'b0};
            3'd3:    w_esc_l = {2'b0, w_grp} + {1'b0, w_grp, 1'b0};
            default: w_esc_l = {w_grp, 2'b0};
        endcase
        w_esc_sum = {1'b0, r_k} + {1'b0, w_cnt, 1'b0};
        w_esc_k   = (w_esc_sum > 5'(arbe_pkg::K_LIMIT)) ? 4'(arbe_pkg::K_LIMIT)
                                                        : w_esc_sum[3:0];
        if (r_vlen <= {1'b0, r_k}) begin
            w_rice_k = (r_k == 4'd0) ? 4'd0 : r_k - 4'd1;
        end else begin
            w_rice_k = ((r_vlen - 5'd1) > 5'(arbe_pkg::K_LIMIT)) ? 4'(arbe_pkg::K_LIMIT)
                                                                 : 4'(r_vlen - 5'd1);
        end
        w_dc_esc   = r_q >= ({13'b0, r_k} + 17'd8);
        w_rice_err = (r_q > 17'(arbe_pkg::MAX_UNARY)) ||
                     (({1'b0, r_q} + {14'b0, r_k} + 18'd1) > 18'(arbe_pkg::CODE_CAP_BITS));

        w_u   = '0;
        w_z   = 1'b0;
        w_l   = '0;
        w_kn  = r_k;
        w_err = 1'b0;
        case (r_func)
            arbe_pkg::FUNC_RAW: begin
                w_l = {2'b0, r_nb};
            end
            arbe_pkg::FUNC_RICE, arbe_pkg::FUNC_SRICE: begin
                if (w_rice_err) begin
                    w_err = 1'b1;
                end else begin
                    w_u  = r_q[6:0];
                    w_z  = 1'b1;
                    w_l  = {3'b0, r_k};
                    w_kn = w_rice_k;
                end
            end
            arbe_pkg::FUNC_RICE_DC, arbe_pkg::FUNC_SRICE_DC: begin
                w_z = 1'b1;
                if (w_dc_esc) begin
                    w_u  = 7'd7 + {3'b0, r_k} + {4'b0, w_cnt};
                    w_l  = w_esc_l;
                    w_kn = w_esc_k;
                end else begin
                    w_u  = r_q[6:0];
                    w_l  = {3'b0, r_k};
                    w_kn = w_rice_k;
                end
            end
            arbe_pkg::FUNC_FLUSH: begin
                w_l = (r_pc != 3'd0) ? (7'd8 - {4'b0, r_pc}) : 7'd0;
            end
            default: begin
                w_l = '0;
            end
        endcase
        w_a = {4'b0, r_pc} + w_u;
        w_e = w_a + {6'b0, w_z};
        w_t = w_e + w_l;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_a    <= w_a;
            r_e    <= w_e;
            r_t    <= w_t;
            r_nres <= (w_t[6:3] > 4'(arbe_pkg::MAX_RESULTS)) ? 3'(arbe_pkg::MAX_RESULTS)
                                                             : w_t[5:3];
            r_kn   <= w_kn;
            r_err  <= w_err;
        end
    end

    assign w_base  = {1'b0, r_bidx, 3'b000};
    assign w_pbase = {r_t[6:3], 3'b000};
    assign w_last  = (r_nres == 3'd0) || (r_bidx == (r_nres - 3'd1));

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_byte[7 - i] = gen_bit(w_base + 7'(i), {4'b0, r_pc}, r_a, r_e, r_t, r_pb, r_v);
            w_pend[7 - i] = gen_bit(w_pbase + 7'(i), {4'b0, r_pc}, r_a, r_e, r_t, r_pb, r_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bidx      <= '0;
            r_pc        <= '0;
            r_pb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.calc) begin
                r_bidx <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (w_last) begin
                    r_pc <= r_t[2:0];
                    r_pb <= w_pend;
                end else begin
                    r_bidx <= r_bidx + 3'd1;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_byte_valid <= (r_nres != 3'd0);
            r_out_byte   <= (r_nres != 3'd0) ? w_byte : 8'd0;
            r_k_out      <= r_kn;
            r_err_out    <= r_err;
            r_last       <= w_last;
        end
    end

    assign o_status.out_free  = !r_out_valid || !i_stall;
    assign o_status.last_byte = w_last;

    assign o_valid          = r_out_valid;
    assign o_byte_valid     = r_byte_valid;
    assign o_out_byte       = r_out_byte;
    assign o_k_out          = r_k_out;
    assign o_overflow_error = r_err_out;
    assign o_last           = r_last;

endmodule

>>> rtl/core/adaptive_rice_bit_encoder_top.sv
// Adaptive Rice bit encoder, top level. Per item: accept, code setup, then one result beat
// per cycle while the output is not stalled; the input stays stalled until the last beat.
// First beat goes via ST_CALC, ST_EMIT and the output register; up to six beats per item.
// Byte emission rate is set by the single output register, one byte per cycle unless stalled.
// Synchronous active-low reset clears the FSM, pending bits/count and output valid; no sweep.
`timescale 1ns / 1ps

module adaptive_rice_bit_encoder_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_func,
    input  logic signed [16:0] i_value,
    input  logic [4:0]        i_nbits,
    input  logic [3:0]        i_k_in,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_byte_valid,
    output logic [7:0]        o_out_byte,
    output logic [3:0]        o_k_out,
    output logic              o_overflow_error,
    output logic              o_last
);

    arbe_pkg::t_cmd    w_cmd;
    arbe_pkg::t_status w_status;

    arbe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    arbe_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_func           (i_func),
        .i_value          (i_value),
        .i_nbits          (i_nbits),
        .i_k_in           (i_k_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_byte_valid     (o_byte_valid),
        .o_out_byte       (o_out_byte),
        .o_k_out          (o_k_out),
        .o_overflow_error (o_overflow_error),
        .o_last           (o_last)
    );

endmodule

>>> rtl/core/arbe_checker.sv
// Port-level checker for the adaptive Rice bit encoder, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module arbe_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [2:0]        i_func,
    input logic signed [16:0] i_value,
    input logic [4:0]        i_nbits,
    input logic [3:0]        i_k_in,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_byte_valid,
    input logic [7:0]        o_out_byte,
    input logic [3:0]        o_k_out,
    input logic              o_overflow_error,
    input logic              o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_byte_valid)
                               && $stable(o_k_out) && $stable(o_last))
        else $error("stalled output beat changed");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_last)
        else $error("empty beat not marked last");

    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow_error |-> !o_byte_valid && o_last)
        else $error("refused code produced a byte");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again right after accept");

endmodule

bind adaptive_rice_bit_encoder_top arbe_checker u_arbe_checker (.*);

>>> tb/adaptive_rice_bit_encoder_top_test.sv
// Self-checking bench for adaptive_rice_bit_encoder_top: a directed table, then random coded values.
// The byte stream is predicted in-bench; depends on arbe_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module adaptive_rice_bit_encoder_top_test;

    localparam logic [2:0] FUNC_NOP6 = 3'd6;
    localparam logic [2:0] FUNC_NOP7 = 3'd7;
    localparam int N_DIR       = 25;
    localparam int N_RAND      = 285;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic       bvalid;
        logic [7:0] data;
        logic [3:0] k;
        logic       err;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic [2:0]  f;
        logic [16:0] val;
        logic [4:0]  nb;
        logic [3:0]  k;
        logic        typed;
        t_beat       want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [2:0]        i_func = '0;
    logic signed [16:0] i_value = '0;
    logic [4:0]        i_nbits = '0;
    logic [3:0]        i_k_in = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic              o_byte_valid;
    logic [7:0]        o_out_byte;
    logic [3:0]        o_k_out;
    logic              o_overflow_error;
    logic              o_last;

    // predictor state
    logic [7:0]  pend_bits = '0;
    int unsigned pend_cnt = 0;
    logic [63:0] code_acc;
    int unsigned code_len;
    logic [3:0]  last_k_out = '0;
    t_beat       step_beats[$];
    t_beat       code_beats_q[$];

    int          mism_cnt = 0;
    int          burst_left = 0;
    int          hold_asks = 0;
    int          hold_done = 0;
    int          hold_cnt = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    t_beat       got_beat;
    t_beat       want_beat;

    // negative values are given as 17-bit patterns: 18000 is -32768, 1FFFF is -1
    t_row dir_rows [N_DIR] = '{
        '{arbe_pkg::FUNC_FLUSH, 17'h00000, 5'd0, 4'd7, 1'b1, '{1'b0, 8'h00, 4'd7, 1'b0, 1'b1}},
        '{arbe_pkg::FUNC_RAW, 17'h000A5, 5'd8, 4'd3, 1'b1, '{1'b1, 8'hA5, 4'd3, 1'b0, 1'b1}},
        '{arbe_pkg::FUNC_RAW, 17'h0FFFF, 5'd16, 4'd3, 1'b0, '0},
        '{arbe_pkg::FUNC_RAW, 17'h00000, 5'd0, 4'd0, 1'b1, '{1'b0, 8'h00, 4'd0, 1'b0, 1'b1}},
        '{arbe_pkg::FUNC_RICE, 17'h0FFFF, 5'd0, 4'd0, 1'b1, '{1'b0, 8'h00, 4'd0, 1'b1, 1'b1}},
        '{arbe_pkg::FUNC_SRICE, 17'h18000, 5'd0, 4'd4, 1'b1, '{1'b0, 8'h00, 4'd4, 1'b1, 1'b1}},
        '{arbe_pkg::FUNC_RICE, 17'h00000, 5'd0, 4'd0, 1'b1, '{1'b0, 8'h00, 4'd0, 1'b0, 1'b1}},
        '{arbe_pkg::FUNC_RICE, 17'h00000, 5'd0, 4'd15, 1'b0, '0},
        '{arbe_pkg::FUNC_RICE, 17'h0FFFF, 5'd0, 4'd15, 1'b0, '0},
        '{arbe_pkg::FUNC_RICE, 17'h00020, 5'd0, 4'd0, 1'b0, '0},
        '{arbe_pkg::FUNC_RICE, 17'h00021, 5'd0, 4'd0, 1'b1, '{1'b0, 8'h00, 4'd0, 1'b1, 1'b1}},
        '{arbe_pkg::FUNC_SRICE, 17'h1FFFF, 5'd0, 4'd0, 1'b0, '0},
        '{arbe_pkg::FUNC_SRICE, 17'h0FFFF, 5'd0, 4'd15, 1'b0, '0},
        '{arbe_pkg::FUNC_RICE_DC, 17'h0FFFF, 5'd0, 4'd0, 1'b0, '0},
        '{arbe_pkg::FUNC_SRICE_DC, 17'h0FFFF, 5'd0, 4'd12, 1'b0, '0},
        '{arbe_pkg::FUNC_RICE_DC, 17'h00007, 5'd0, 4'd0, 1'b0, '0},
        '{arbe_pkg::FUNC_RICE_DC, 17'h00008, 5'd0, 4'd0, 1'b0, '0},
        '{arbe_pkg::FUNC_RAW, 17'h1FFFF, 5'd31, 4'd5, 1'b0, '0},
        '{arbe_pkg::FUNC_RAW, 17'h0AAAA, 5'd17, 4'd5, 1'b0, '0},
        '{FUNC_NOP6, 17'h00000, 5'd0, 4'd9, 1'b1, '{1'b0, 8'h00, 4'd9, 1'b0, 1'b1}},
        '{FUNC_NOP7, 17'h00000, 5'd0, 4'd2, 1'b1, '{1'b0, 8'h00, 4'd2, 1'b0, 1'b1}},
        '{arbe_pkg::FUNC_FLUSH, 17'h00000, 5'd0, 4'd1, 1'b0, '0},
        '{arbe_pkg::FUNC_FLUSH, 17'h00000, 5'd0, 4'd1, 1'b1, '{1'b0, 8'h00, 4'd1, 1'b0, 1'b1}},
        '{arbe_pkg::FUNC_SRICE_DC, 17'h1FFFF, 5'd0, 4'd15, 1'b0, '0},
        '{arbe_pkg::FUNC_SRICE_DC, 17'h18000, 5'd0, 4'd0, 1'b0, '0}
    };

    adaptive_rice_bit_encoder_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_value          (i_value),
        .i_nbits          (i_nbits),
        .i_k_in           (i_k_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_byte_valid     (o_byte_valid),
        .o_out_byte       (o_out_byte),
        .o_k_out          (o_k_out),
        .o_overflow_error (o_overflow_error),
        .o_last           (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void add_bits(logic [63:0] v, int unsigned n);
        if (n > 0) begin
            code_acc = (code_acc << n) | (v & ((64'd1 << n) - 64'd1));
            code_len += n;
        end
    endfunction

    function automatic void add_rice(int unsigned v, int unsigned k, int unsigned q);
        add_bits((64'd1 << q) - 64'd1, q);
        add_bits(64'd0, 1);
        add_bits(64'(v), k);
    endfunction

    function automatic int unsigned zigzag(logic [16:0] s);
        if (s[16]) return ((32'h1FFFF - 32'(s)) << 1) | 32'd1;
        return 32'(s) << 1;
    endfunction

    function automatic logic [3:0] next_k(int unsigned k, int unsigned q);
        int unsigned kk;
        kk = k;
        if (q == 0) return (k > 0) ? 4'(k - 1) : 4'd0;
        while (q > 1) begin
            kk++;
            q = q >> 1;
        end
        return (kk > arbe_pkg::K_LIMIT) ? 4'(arbe_pkg::K_LIMIT) : 4'(kk);
    endfunction

    // code one item into the byte stream and fill step_beats with the beats it yields
    function automatic void rice_pack_predict(logic [2:0] f, logic [16:0] val, logic [4:0] nb,
                                              logic [3:0] k);
        int unsigned v, q, grp, ngrp, t, nres, kw;
        logic [3:0]  kn;
        logic        err;
        t_beat       b;
        kw = k;
        kn = k;
        err = 1'b0;
        code_acc = 64'(pend_bits) >> (8 - pend_cnt);
        code_len = pend_cnt;
        step_beats.delete();
        case (f)
            arbe_pkg::FUNC_RAW: add_bits(64'(val), (nb > 16) ? 16 : nb);
            arbe_pkg::FUNC_RICE, arbe_pkg::FUNC_SRICE: begin
                v = (f == arbe_pkg::FUNC_RICE) ? 32'(val & arbe_pkg::VALUE_MASK) : zigzag(val);
                q = v >> kw;
                if (q > arbe_pkg::MAX_UNARY || q + kw + 1 > arbe_pkg::CODE_CAP_BITS) begin
                    err = 1'b1;
                end else begin
                    add_rice(v, kw, q);
                    kn = next_k(kw, q);
                end
            end
            arbe_pkg::FUNC_RICE_DC, arbe_pkg::FUNC_SRICE_DC: begin
                v = (f == arbe_pkg::FUNC_RICE_DC) ? 32'(val & arbe_pkg::VALUE_MASK)
                                                  : zigzag(val);
                q = v >> kw;
                if (q >= 8 + kw) begin
                    grp = 5 + kw;
                    ngrp = 1;
                    t = v;
                    while ((t >> grp) != 0) begin
                        t = t >> grp;
                        ngrp++;
                    end
                    add_bits((64'd1 << (7 + kw + ngrp)) - 64'd1, 7 + kw + ngrp);
                    add_bits(64'd0, 1);
                    add_bits(64'(v), ngrp * grp);
                    kn = (kw + 2 * ngrp > arbe_pkg::K_LIMIT) ? 4'(arbe_pkg::K_LIMIT)
                                                             : 4'(kw + 2 * ngrp);
                end else begin
                    add_rice(v, kw, q);
                    kn = next_k(kw, q);
                end
            end
            arbe_pkg::FUNC_FLUSH: if (code_len > 0) add_bits(64'd0, 8 - code_len);
            default: ;
        endcase
        nres = code_len / 8;
        if (nres > arbe_pkg::MAX_RESULTS) nres = arbe_pkg::MAX_RESULTS;
        for (int i = 0; i < nres; i++) begin
            b.bvalid = 1'b1;
            b.data = 8'(code_acc >> (code_len - 8));
            b.k = kn;
            b.err = err;
            b.last = (i + 1 == nres);
            step_beats.push_back(b);
            code_len -= 8;
        end
        if (nres == 0) step_beats.push_back(t_beat'{1'b0, 8'h00, kn, err, 1'b1});
        pend_cnt = code_len & 7;
        pend_bits = 8'((code_acc & ((64'd1 << pend_cnt) - 64'd1)) << (8 - pend_cnt));
        last_k_out = kn;
    endfunction

    function automatic logic [16:0] pick_value(logic [2:0] f, int unsigned k);
        int unsigned len, m;
        if (f == arbe_pkg::FUNC_RAW) return 17'($urandom_range(0, 98303) - 32768);
        len = ($urandom_range(0, 9) < 7) ? k + $urandom_range(0, 3) : $urandom_range(0, 16);
        if (len > 16) len = 16;
        m = $urandom & ((32'd1 << len) - 1);
        if (f == arbe_pkg::FUNC_SRICE || f == arbe_pkg::FUNC_SRICE_DC) begin
            if ($urandom_range(0, 1) == 1) return 17'(-int'(m >> 1) - 1);
            return ($urandom_range(0, 9) == 0) ? 17'(m) : 17'(m >> 1);
        end
        return 17'(m);
    endfunction

    function automatic logic [2:0] pick_func();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 18) return arbe_pkg::FUNC_RAW;
        if (r < 38) return arbe_pkg::FUNC_RICE;
        if (r < 58) return arbe_pkg::FUNC_SRICE;
        if (r < 73) return arbe_pkg::FUNC_RICE_DC;
        if (r < 88) return arbe_pkg::FUNC_SRICE_DC;
        if (r < 96) return arbe_pkg::FUNC_FLUSH;
        if (r < 98) return FUNC_NOP6;
        return FUNC_NOP7;
    endfunction

    // offer one item in bursts with random gaps; queue its expected beats on accept
    task automatic send_item(logic [2:0] f, logic [16:0] val, logic [4:0] nb, logic [3:0] k,
                             logic typed, t_beat want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_func  <= f;
        i_value <= val;
        i_nbits <= nb;
        i_k_in  <= k;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        rice_pack_predict(f, val, nb, k);
        if (typed) begin
            code_beats_q.push_back(want);
        end else begin
            foreach (step_beats[j]) code_beats_q.push_back(step_beats[j]);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (code_beats_q.size() != 0);
    endtask

    // receiver: stall pattern by phases, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall <= 1'b1;
        end else if (hold_asks != hold_done) begin
            hold_done <= hold_asks;
            hold_cnt <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(10, 60);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= ~i_stall;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_beat = '{o_byte_valid, o_out_byte, o_k_out, o_overflow_error, o_last};
            if (code_beats_q.size() == 0) begin
                mism_cnt++;
                if (mism_cnt <= MAX_SHOWN)
                    $display("%0t: unexpected beat bv=%0b byte=%02h k=%0d err=%0b last=%0b",
                             $time, got_beat.bvalid, got_beat.data, got_beat.k, got_beat.err,
                             got_beat.last);
            end else begin
                want_beat = code_beats_q.pop_front();
                if (got_beat.bvalid !== want_beat.bvalid || got_beat.data !== want_beat.data ||
                    got_beat.k !== want_beat.k || got_beat.err !== want_beat.err ||
                    got_beat.last !== want_beat.last) begin
                    mism_cnt++;
                    if (mism_cnt <= MAX_SHOWN)
                        $display("%0t: exp bv=%0b byte=%02h k=%0d err=%0b last=%0b, %s",
                                 $time, want_beat.bvalid, want_beat.data, want_beat.k,
                                 want_beat.err, want_beat.last,
                                 $sformatf("got bv=%0b byte=%02h k=%0d err=%0b last=%0b",
                                           got_beat.bvalid, got_beat.data, got_beat.k,
                                           got_beat.err, got_beat.last));
                end
            end
        end
    end

    initial begin
        logic [2:0] f;
        logic [3:0] k;
        logic [4:0] nb;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[r])
            send_item(dir_rows[r].f, dir_rows[r].val, dir_rows[r].nb, dir_rows[r].k,
                      dir_rows[r].typed, dir_rows[r].want);
        wait_drained();
        for (int n = 0; n < N_RAND; n++) begin
            if (n == 100) hold_asks <= hold_asks + 1;
            if (n == 200) wait_drained();
            f = pick_func();
            k = ($urandom_range(0, 3) != 0) ? last_k_out : 4'($urandom_range(0, 15));
            nb = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                              : 5'($urandom_range(0, 16));
            send_item(f, pick_value(f, k), nb, k, 1'b0, '0);
        end
        i_valid <= 1'b0;
        while (code_beats_q.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        if (mism_cnt == 0 && code_beats_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
